// ===== sv/bsfe_pkg.sv =====
// Shared types and constants of the bitmap shape fill engine.
package bsfe_pkg;

  localparam int CrdW   = 8;
  localparam int SpanW  = 9;
  localparam int SqW    = 16;
  localparam int RootW  = 8;
  localparam int OpW    = 3;
  localparam int InDataW  = 56;
  localparam int OutBitsW = 64;
  localparam int OutDataW = 72;

  typedef enum logic [OpW-1:0] {
    OP_FILL  = 3'd0,
    OP_LINE  = 3'd1,
    OP_TRI   = 3'd2,
    OP_DISC  = 3'd3,
    OP_ERASE = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    K_SPAN,
    K_TRI,
    K_DISC,
    K_READ
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              paint;
    logic [SpanW-1:0]  row_lo;
    logic [SpanW-1:0]  row_hi;
    logic [CrdW-1:0]   col_lo;
    logic [SpanW-1:0]  col_hi;
    logic [CrdW-1:0]   ctr_row;
    logic [SqW-1:0]    rad_sq;
  } cmd_t;

endpackage

// ===== sv/bsfe_front.sv =====
// Command decoder: accepts input beats and turns them into row spans clipped to the picture and column spans.
module bsfe_front import bsfe_pkg::*; #(
  parameter int PIC_ROWS = 32
) (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // operation, row_pos, col_pos, height, width, end_col, radius, zero fill
  input  logic [InDataW-1:0] s_axis_tdata,
  output logic               push_o,
  output cmd_t               cmd_o,
  input  logic               full_i
);

  localparam logic [SpanW-1:0] RowsLim = SpanW'(PIC_ROWS);

  logic [OpW-1:0]   op;
  logic [SpanW-1:0] r9, c9, h9, w9, e9, rad9;
  logic [SpanW-1:0] rect_hi, line_hi, disc_lo, disc_hi;
  logic [SpanW-1:0] sum_h, sum_one, sum_rad;
  logic             known;

  assign op   = s_axis_tdata[2:0];
  assign r9   = SpanW'(s_axis_tdata[10:3]);
  assign c9   = SpanW'(s_axis_tdata[18:11]);
  assign h9   = SpanW'(s_axis_tdata[26:19]);
  assign w9   = SpanW'(s_axis_tdata[34:27]);
  assign e9   = SpanW'(s_axis_tdata[42:35]);
  assign rad9 = SpanW'(s_axis_tdata[50:43]);

  assign sum_h   = r9 + h9;
  assign sum_one = r9 + SpanW'(1);
  assign sum_rad = r9 + rad9 + SpanW'(1);
  assign rect_hi = (sum_h > RowsLim) ? RowsLim : sum_h;
  assign line_hi = (e9 < c9) ? r9 : ((sum_one > RowsLim) ? RowsLim : sum_one);
  assign disc_lo = (r9 >= rad9) ? (r9 - rad9) : '0;
  assign disc_hi = (sum_rad > RowsLim) ? RowsLim : sum_rad;

  always_comb begin
    cmd_o         = '0;
    cmd_o.row_lo  = r9;
    cmd_o.col_lo  = s_axis_tdata[18:11];
    cmd_o.ctr_row = s_axis_tdata[10:3];
    cmd_o.rad_sq  = SqW'(s_axis_tdata[50:43]) * SqW'(s_axis_tdata[50:43]);
    known         = 1'b1;
    case (op_e'(op))
      OP_FILL, OP_ERASE: begin
        cmd_o.kind   = K_SPAN;
        cmd_o.paint  = (op_e'(op) == OP_FILL);
        cmd_o.row_hi = rect_hi;
        cmd_o.col_hi = c9 + w9;
      end
      OP_LINE: begin
        cmd_o.kind   = K_SPAN;
        cmd_o.paint  = 1'b1;
        cmd_o.row_hi = line_hi;
        cmd_o.col_hi = e9 + SpanW'(1);
      end
      OP_TRI: begin
        cmd_o.kind   = K_TRI;
        cmd_o.paint  = 1'b1;
        cmd_o.row_hi = rect_hi;
        cmd_o.col_hi = c9 + SpanW'(1);
      end
      OP_DISC: begin
        cmd_o.kind   = K_DISC;
        cmd_o.paint  = 1'b1;
        cmd_o.row_lo = disc_lo;
        cmd_o.row_hi = disc_hi;
      end
      OP_READ: begin
        cmd_o.kind = K_READ;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i && known;

endmodule

// ===== sv/bsfe_queue.sv =====
// Two-entry command queue between the decoder and the drawing sequencer.
module bsfe_queue import bsfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== sv/bsfe_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module bsfe_isqrt import bsfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   value_i,
  output logic             busy_o,
  output logic [RootW-1:0] root_o
);

  localparam logic [SqW-1:0] TopBit = SqW'(1) << (SqW - 2);

  logic [SqW-1:0] op_q, op_d, res_q, res_d, one_q, one_d;
  logic [SqW:0]   trial;
  logic           busy_q, busy_d;

  assign trial  = {1'b0, res_q} + {1'b0, one_q};
  assign busy_o = busy_q;
  assign root_o = res_q[RootW-1:0];

  always_comb begin
    op_d   = op_q;
    res_d  = res_q;
    one_d  = one_q;
    busy_d = busy_q;
    if (start_i) begin
      op_d   = value_i;
      res_d  = '0;
      one_d  = TopBit;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, op_q} >= trial) begin
        op_d  = op_q - trial[SqW-1:0];
        res_d = (res_q >> 1) + one_q;
      end else begin
        res_d = res_q >> 1;
      end
      one_d  = one_q >> 2;
      busy_d = (one_q != SqW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    res_q <= res_d;
    one_q <= one_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

// ===== sv/bsfe_back.sv =====
// Drawing sequencer: row-by-row read-modify-write of the framebuffer and row readout.
module bsfe_back import bsfe_pkg::*; #(
  parameter int PIC_ROWS = 32,
  parameter int PIC_COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cmd_t                q_data_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // row_index, row_bits
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int RowAw = (PIC_ROWS > 1) ? $clog2(PIC_ROWS) : 1;
  localparam logic [SpanW-1:0] RowsLim = SpanW'(PIC_ROWS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_DMUL,
    S_DCHK,
    S_DSQW,
    S_RDOUT
  } state_e;

  function automatic logic [PIC_COLS-1:0] span_mask(logic [SpanW-1:0] lo,
                                                    logic [SpanW-1:0] hi);
    logic [PIC_COLS-1:0] m;
    for (int j = 0; j < PIC_COLS; j++) begin
      m[j] = (SpanW'(j) >= lo) && (SpanW'(j) < hi);
    end
    return m;
  endfunction

  state_e                state_q, state_d;
  cmd_t                  cur_q, cur_d;
  logic [SpanW-1:0]      row_q, row_d, hi_q, hi_d;
  logic [SqW-1:0]        di2_q, di2_d;
  logic                  pend_vld_q, pend_vld_d, pend_set_q, pend_set_d;
  logic [RowAw-1:0]      pend_row_q, pend_row_d;
  logic [PIC_COLS-1:0]   pend_mask_q, pend_mask_d;
  logic                  rd_oob_q, rd_oob_d;
  logic                  out_vld_q, out_vld_d;
  logic [CrdW-1:0]       out_row_q, out_row_d;
  logic [OutBitsW-1:0]   out_bits_q, out_bits_d;

  logic [PIC_COLS-1:0]   mem [PIC_ROWS];
  logic [PIC_ROWS-1:0]   row_vld_q;
  logic [PIC_COLS-1:0]   rd_raw_q, fwd_q, rd_data, wdata;
  logic                  rd_ok_q, rd_fwd_q;
  logic                  re;
  logic [RowAw-1:0]      raddr;

  logic                  sq_start, sq_busy;
  logic [RootW-1:0]      sq_root;
  logic [SqW-1:0]        sq_val;
  logic [CrdW-1:0]       di;
  logic [SpanW-1:0]      dlo, dhi, root9, ctr9;

  bsfe_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_val),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  assign rd_data = rd_fwd_q ? fwd_q : (rd_ok_q ? rd_raw_q : '0);
  assign wdata   = pend_set_q ? (rd_data | pend_mask_q) : (rd_data & ~pend_mask_q);

  assign di    = (row_q[CrdW-1:0] >= cur_q.ctr_row) ? (row_q[CrdW-1:0] - cur_q.ctr_row)
                                                    : (cur_q.ctr_row - row_q[CrdW-1:0]);
  assign sq_val = cur_q.rad_sq - di2_q;
  assign root9  = SpanW'(sq_root);
  assign ctr9   = SpanW'(cur_q.col_lo);
  assign dlo    = (ctr9 >= root9) ? (ctr9 - root9) : '0;
  assign dhi    = ctr9 + root9 + SpanW'(1);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    row_d       = row_q;
    hi_d        = hi_q;
    di2_d       = di2_q;
    pend_vld_d  = 1'b0;
    pend_set_d  = pend_set_q;
    pend_row_d  = pend_row_q;
    pend_mask_d = pend_mask_q;
    rd_oob_d    = rd_oob_q;
    out_vld_d   = out_vld_q;
    out_row_d   = out_row_q;
    out_bits_d  = out_bits_q;
    q_pop_o     = 1'b0;
    re          = 1'b0;
    raddr       = row_q[RowAw-1:0];
    sq_start    = 1'b0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          row_d   = q_data_i.row_lo;
          hi_d    = q_data_i.col_hi;
          case (q_data_i.kind)
            K_READ: begin
              raddr    = q_data_i.row_lo[RowAw-1:0];
              re       = (q_data_i.row_lo < RowsLim);
              rd_oob_d = !(q_data_i.row_lo < RowsLim);
              state_d  = S_RDOUT;
            end
            K_DISC: begin
              state_d = S_DMUL;
            end
            default: begin
              state_d = S_ROW;
            end
          endcase
        end
      end
      S_ROW: begin
        if (row_q < cur_q.row_hi) begin
          re          = 1'b1;
          pend_vld_d  = 1'b1;
          pend_row_d  = row_q[RowAw-1:0];
          pend_set_d  = cur_q.paint;
          pend_mask_d = span_mask(SpanW'(cur_q.col_lo), hi_q);
          row_d       = row_q + SpanW'(1);
          if (cur_q.kind == K_TRI) begin
            hi_d = hi_q + SpanW'(1);
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DMUL: begin
        if (row_q < cur_q.row_hi) begin
          di2_d   = SqW'(di) * SqW'(di);
          state_d = S_DCHK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DCHK: begin
        if (di2_q > cur_q.rad_sq) begin
          row_d   = row_q + SpanW'(1);
          state_d = S_DMUL;
        end else begin
          sq_start = 1'b1;
          state_d  = S_DSQW;
        end
      end
      S_DSQW: begin
        if (!sq_busy) begin
          re          = 1'b1;
          pend_vld_d  = 1'b1;
          pend_row_d  = row_q[RowAw-1:0];
          pend_set_d  = 1'b1;
          pend_mask_d = span_mask(dlo, dhi);
          row_d       = row_q + SpanW'(1);
          state_d     = S_DMUL;
        end
      end
      S_RDOUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_row_d  = cur_q.row_lo[CrdW-1:0];
          out_bits_d = rd_oob_q ? '0 : OutBitsW'(rd_data);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_bits_q, out_row_q};

  always_ff @(posedge clk_i) begin
    if (pend_vld_q) begin
      mem[pend_row_q] <= wdata;
    end
    if (re) begin
      rd_raw_q <= mem[raddr];
      fwd_q    <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    row_q       <= row_d;
    hi_q        <= hi_d;
    di2_q       <= di2_d;
    pend_set_q  <= pend_set_d;
    pend_row_q  <= pend_row_d;
    pend_mask_q <= pend_mask_d;
    rd_oob_q    <= rd_oob_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_row_q  <= '0;
      out_bits_q <= '0;
      row_vld_q  <= '0;
      rd_ok_q    <= 1'b0;
      rd_fwd_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      out_row_q  <= out_row_d;
      out_bits_q <= out_bits_d;
      if (pend_vld_q) begin
        row_vld_q[pend_row_q] <= 1'b1;
      end
      if (re) begin
        rd_ok_q  <= row_vld_q[raddr];
        rd_fwd_q <= pend_vld_q && (pend_row_q == raddr);
      end
    end
  end

`ifndef SYNTHESIS
  a_write_in_picture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (SpanW'(pend_row_q) < RowsLim))
    else $error("framebuffer write outside the picture");

  a_rows_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && $past(pend_vld_q)) |-> (pend_row_q != $past(pend_row_q)))
    else $error("two back-to-back writes hit the same row");

  a_sqrt_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RDOUT) |-> !sq_busy)
    else $error("square root unit busy outside a disc command");
`endif

endmodule

// ===== sv/bitmap_shape_fill_engine.sv =====
// Top level of the bitmap shape fill engine.
//
// Commands arrive as beats on the s_axis channel; row readouts leave on m_axis.
// Each command draws a filled rectangle, a horizontal line, a right triangle or
// a filled disc, erases a rectangle, or reads one row of the picture. Only a
// read returns a beat, carrying the row number and its pixels.
// A decoder turns each command into row and column spans, with the rows clipped
// to the picture, and places it in a two-entry queue, so input beats keep flowing
// while the sequencer works. Rectangles, lines and triangles are written row by row.
// A disc is also drawn row by row; the eight-step square root unit finds the
// span of each covered row.
// With the sequencer idle, a read's beat follows the queue, the row read and the output register.
// The framebuffer is one read and one write port memory with a valid bit per
// row; reset clears the valid bits, so the whole picture reads blank at once.
// A stalled receiver holds the result in the output register; the sequencer
// waits at the next read and the queue fills before s_axis_tready drops.
module bitmap_shape_fill_engine import bsfe_pkg::*; #(
  parameter int PIC_ROWS = 32,
  parameter int PIC_COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // operation, row_pos, col_pos, height, width, end_col, radius, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // row_index, row_bits
  output logic [OutDataW-1:0] m_axis_tdata
);

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, q_valid;

  bsfe_front #(
    .PIC_ROWS (PIC_ROWS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (full)
  );

  bsfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  bsfe_back #(
    .PIC_ROWS (PIC_ROWS),
    .PIC_COLS (PIC_COLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_cmd),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
